// ===== rtl/core/ped_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ped_pkg: shared types and constants of the pedometer step detector
// Field widths, register map, activity codes, controller states and the
// command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package ped_pkg;

    localparam int TIME_BITS_DEF = 32;

    // field widths
    localparam int ACCEL_W  = 16;
    localparam int STAMP_W  = 32;
    localparam int STEP_W   = 16;
    localparam int ACT_W    = 2;
    localparam int FREQ_W   = 16;
    localparam int LVL_W    = 21;   // holds [-4096, 782336]
    localparam int SUM_W    = 32;   // x^2 + y^2 + z^2
    localparam int Q12_SH   = 12;

    // register widths
    localparam int ALPHA_W  = 9;
    localparam int THR_W    = 20;
    localparam int MS_W     = 16;

    // shared multiplier operands
    localparam int MUL_A_W  = 17;
    localparam int MUL_B_W  = 22;
    localparam int MUL_W    = MUL_A_W + MUL_B_W;
    localparam int ACC_W    = 32;

    // arithmetic constants
    localparam int ONE_G_SQ    = 4096;     // 1 g^2 in Q12
    localparam int ALPHA_ONE   = 256;      // 1.0 in Q8
    localparam int AVG_FLOOR   = 25;       // 0.1 Hz in Q8
    localparam int DIVIDEND    = 256000;   // 1000 ms * 256
    localparam int DIVIDEND_W  = 18;
    localparam int CNT_W       = $clog2(DIVIDEND_W + 1);

    // register reset values
    localparam int ALPHA_RST   = 77;
    localparam int THR_RST     = 1638;
    localparam int GAP_RST     = 350;
    localparam int IDLE_RST    = 2000;
    localparam int STARTUP_RST = 500;
    localparam int RUN_RST     = 563;

    // APB register map, word index
    localparam int CFG_ADDR_W  = 5;
    localparam int CFG_DATA_W  = 32;
    localparam int REG_IDX_W   = 3;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_ALPHA   = 3'd0,
        REG_THR     = 3'd1,
        REG_GAP     = 3'd2,
        REG_IDLE    = 3'd3,
        REG_STARTUP = 3'd4,
        REG_RUN     = 3'd5
    } reg_idx_t;

    typedef enum logic [ACT_W-1:0] {
        ACT_IDLE = 2'd0,
        ACT_WALK = 2'd1,
        ACT_RUN  = 2'd2
    } activity_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SQ_Z,
        ST_FILT_A,
        ST_FILT_B,
        ST_DECIDE,
        ST_DIV,
        ST_AVG_A,
        ST_AVG_B,
        ST_OUT
    } ctrl_state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_CHECK,
        OP_SQ_X,
        OP_SQ_Y,
        OP_SQ_Z,
        OP_FILT_A,
        OP_FILT_B,
        OP_DECIDE,
        OP_AVG_A,
        OP_AVG_B
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   div_start;
        logic   load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic is_clear;
        logic settle;
        logic step_hit;
        logic had_step;
        logic div_done;
    } dp_status_t;

    typedef struct packed {
        logic [ALPHA_W-1:0] alpha;
        logic [THR_W-1:0]   threshold;
        logic [MS_W-1:0]    min_gap;
        logic [MS_W-1:0]    idle;
        logic [MS_W-1:0]    startup;
        logic [MS_W-1:0]    run_thr;
    } cfg_t;

endpackage

// ===== rtl/core/ped_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ped_cfg: configuration register file
// APB slave with six registers at word addresses; zero wait states.
// ----------------------------------------------------------------------------
module ped_cfg
    import ped_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t                 cfg_reg;
    cfg_t                 cfg_next;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[CFG_ADDR_W-1:2];
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                REG_ALPHA:   cfg_next.alpha     = pwdata[ALPHA_W-1:0];
                REG_THR:     cfg_next.threshold = pwdata[THR_W-1:0];
                REG_GAP:     cfg_next.min_gap   = pwdata[MS_W-1:0];
                REG_IDLE:    cfg_next.idle      = pwdata[MS_W-1:0];
                REG_STARTUP: cfg_next.startup   = pwdata[MS_W-1:0];
                REG_RUN:     cfg_next.run_thr   = pwdata[MS_W-1:0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_ALPHA:   prdata = CFG_DATA_W'(cfg_reg.alpha);
            REG_THR:     prdata = CFG_DATA_W'(cfg_reg.threshold);
            REG_GAP:     prdata = CFG_DATA_W'(cfg_reg.min_gap);
            REG_IDLE:    prdata = CFG_DATA_W'(cfg_reg.idle);
            REG_STARTUP: prdata = CFG_DATA_W'(cfg_reg.startup);
            REG_RUN:     prdata = CFG_DATA_W'(cfg_reg.run_thr);
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.alpha     <= ALPHA_W'(ALPHA_RST);
            cfg_reg.threshold <= THR_W'(THR_RST);
            cfg_reg.min_gap   <= MS_W'(GAP_RST);
            cfg_reg.idle      <= MS_W'(IDLE_RST);
            cfg_reg.startup   <= MS_W'(STARTUP_RST);
            cfg_reg.run_thr   <= MS_W'(RUN_RST);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== rtl/core/ped_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ped_div: radix-2 restoring divider for the step frequency
// Divides the fixed 256000 by the step interval, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module ped_div
    import ped_pkg::*;
#(
    parameter int DVSR_W = TIME_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DVSR_W-1:0]     divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DVSR_W-1:0]     rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DVSR_W-1:0]     dvsr_reg, dvsr_next;
    logic [DVSR_W:0]       trial;
    logic                  fits;

    // shift the next dividend bit into the partial remainder
    assign trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign fits  = trial >= {1'b0, dvsr_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvsr_next = dvsr_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIVIDEND_W);
            rem_next  = '0;
            quo_next  = DIVIDEND_W'(DIVIDEND);
            dvsr_next = divisor;
        end else if (busy_reg) begin
            rem_next = fits ? DVSR_W'(trial - {1'b0, dvsr_reg}) : trial[DVSR_W-1:0];
            quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dvsr_reg <= dvsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/core/ped_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ped_dpath: detector datapath
// Holds the detector state, one shared multiplier, the frequency divider and
// the result register; every step is ordered by the controller.
// ----------------------------------------------------------------------------
module ped_dpath
    import ped_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  dp_cmd_t             cmd,
    output dp_status_t          status,
    input  cfg_t                cfg,
    input  logic                in_cmd,
    input  logic [ACCEL_W-1:0]  in_x,
    input  logic [ACCEL_W-1:0]  in_y,
    input  logic [ACCEL_W-1:0]  in_z,
    input  logic [STAMP_W-1:0]  in_time,
    output logic [STEP_W-1:0]   out_steps,
    output logic [ACT_W-1:0]    out_activity,
    output logic                out_seen,
    output logic                out_settle
);

    // detector state
    logic                        started_reg, started_next;
    logic [TIME_BITS-1:0]        start_time_reg, start_time_next;
    logic signed [LVL_W-1:0]     level_reg, level_next;
    logic signed [LVL_W-1:0]     w_old_reg, w_old_next;
    logic signed [LVL_W-1:0]     w_mid_reg, w_mid_next;
    logic signed [LVL_W-1:0]     w_new_reg, w_new_next;
    logic                        had_step_reg, had_step_next;
    logic [TIME_BITS-1:0]        last_step_reg, last_step_next;
    logic [STEP_W-1:0]           steps_reg, steps_next;
    activity_t                   act_reg, act_next;
    logic [FREQ_W-1:0]           avg_reg, avg_next;

    // per-word working registers
    logic                        cmd_reg, cmd_next;
    logic signed [ACCEL_W-1:0]   x_reg, x_next;
    logic signed [ACCEL_W-1:0]   y_reg, y_next;
    logic signed [ACCEL_W-1:0]   z_reg, z_next;
    logic [TIME_BITS-1:0]        now_reg, now_next;
    logic [SUM_W-1:0]            sum_reg, sum_next;
    logic signed [ACC_W-1:0]     prod_reg, prod_next;
    logic [TIME_BITS-1:0]        since_reg, since_next;
    logic [FREQ_W-1:0]           inst_reg, inst_next;
    logic                        seen_reg, seen_next;
    logic                        settle_reg, settle_next;
    logic [STEP_W-1:0]           o_steps_reg, o_steps_next;
    logic [ACT_W-1:0]            o_act_reg, o_act_next;
    logic                        o_seen_reg, o_seen_next;
    logic                        o_settle_reg, o_settle_next;

    logic [ALPHA_W-1:0]          alpha_w;
    logic [ALPHA_W-1:0]          beta_w;
    logic signed [LVL_W-1:0]     dev_w;
    logic signed [MUL_A_W-1:0]   mul_a;
    logic signed [MUL_B_W-1:0]   mul_b;
    logic signed [MUL_W-1:0]     mul_p;
    logic signed [ACC_W-1:0]     acc_w;
    logic signed [LVL_W-1:0]     lvl_new;
    logic [FREQ_W-1:0]           avg_wtd;
    logic [TIME_BITS-1:0]        start_eff;
    logic [TIME_BITS-1:0]        elapsed;
    logic                        settle_w;
    logic                        peak_w;
    logic                        gap_ok;
    logic                        idle_w;
    logic                        div_done;
    logic [DIVIDEND_W-1:0]       quotient;
    logic [FREQ_W-1:0]           inst_sat;

    assign alpha_w = (cfg.alpha > ALPHA_W'(ALPHA_ONE)) ? ALPHA_W'(ALPHA_ONE) : cfg.alpha;
    assign beta_w  = ALPHA_W'(ALPHA_ONE) - alpha_w;

    // squared magnitude in Q12 less 1 g^2
    assign dev_w = $signed({1'b0, sum_reg[SUM_W-1:Q12_SH]}) - $signed(LVL_W'(ONE_G_SQ));

    always_comb begin
        unique case (cmd.op)
            OP_SQ_X:   begin mul_a = MUL_A_W'(x_reg);   mul_b = MUL_B_W'(x_reg);     end
            OP_SQ_Y:   begin mul_a = MUL_A_W'(y_reg);   mul_b = MUL_B_W'(y_reg);     end
            OP_SQ_Z:   begin mul_a = MUL_A_W'(z_reg);   mul_b = MUL_B_W'(z_reg);     end
            OP_FILT_A: begin mul_a = MUL_A_W'(alpha_w); mul_b = MUL_B_W'(dev_w);     end
            OP_FILT_B: begin mul_a = MUL_A_W'(beta_w);  mul_b = MUL_B_W'(level_reg); end
            OP_AVG_A:  begin mul_a = MUL_A_W'(alpha_w); mul_b = MUL_B_W'(inst_sat);  end
            OP_AVG_B:  begin mul_a = MUL_A_W'(beta_w);  mul_b = MUL_B_W'(avg_reg);   end
            default:   begin mul_a = '0;                mul_b = '0;                  end
        endcase
    end

    assign mul_p   = mul_a * mul_b;
    assign acc_w   = prod_reg + $signed(mul_p[ACC_W-1:0]);
    assign lvl_new = LVL_W'(acc_w >>> 8);
    assign avg_wtd = FREQ_W'(acc_w >>> 8);

    assign start_eff = started_reg ? start_time_reg : now_reg;
    assign elapsed   = now_reg - start_eff;
    assign settle_w  = elapsed < TIME_BITS'(cfg.startup);

    assign gap_ok = !had_step_reg || (since_reg > TIME_BITS'(cfg.min_gap));
    assign peak_w = (w_mid_reg > w_old_reg) && (w_mid_reg > w_new_reg)
                    && ($signed({w_mid_reg[LVL_W-1], w_mid_reg})
                        > $signed({2'b00, cfg.threshold}))
                    && gap_ok;
    assign idle_w = had_step_reg && (since_reg > TIME_BITS'(cfg.idle));

    assign inst_sat = (|quotient[DIVIDEND_W-1:FREQ_W]) ? '1 : quotient[FREQ_W-1:0];

    ped_div #(
        .DVSR_W   (TIME_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .divisor  (since_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    assign status.is_clear = cmd_reg;
    assign status.settle   = settle_w;
    assign status.step_hit = peak_w;
    assign status.had_step = had_step_reg;
    assign status.div_done = div_done;

    always_comb begin
        started_next    = started_reg;
        start_time_next = start_time_reg;
        level_next      = level_reg;
        w_old_next      = w_old_reg;
        w_mid_next      = w_mid_reg;
        w_new_next      = w_new_reg;
        had_step_next   = had_step_reg;
        last_step_next  = last_step_reg;
        steps_next      = steps_reg;
        act_next        = act_reg;
        avg_next        = avg_reg;
        cmd_next        = cmd_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        z_next          = z_reg;
        now_next        = now_reg;
        sum_next        = sum_reg;
        prod_next       = prod_reg;
        since_next      = since_reg;
        inst_next       = inst_reg;
        seen_next       = seen_reg;
        settle_next     = settle_reg;

        unique case (cmd.op)
            OP_LATCH: begin
                cmd_next    = in_cmd;
                x_next      = in_x;
                y_next      = in_y;
                z_next      = in_z;
                now_next    = in_time[TIME_BITS-1:0];
                seen_next   = 1'b0;
                settle_next = 1'b0;
            end
            OP_CHECK: begin
                if (cmd_reg) begin
                    started_next    = 1'b0;
                    start_time_next = '0;
                    level_next      = '0;
                    w_old_next      = '0;
                    w_mid_next      = '0;
                    w_new_next      = '0;
                    had_step_next   = 1'b0;
                    last_step_next  = '0;
                    steps_next      = '0;
                    act_next        = ACT_IDLE;
                    avg_next        = '0;
                end else begin
                    if (!started_reg) begin
                        started_next    = 1'b1;
                        start_time_next = now_reg;
                    end
                    settle_next = settle_w;
                end
            end
            OP_SQ_X: sum_next = mul_p[SUM_W-1:0];
            OP_SQ_Y, OP_SQ_Z: sum_next = sum_reg + mul_p[SUM_W-1:0];
            OP_FILT_A: prod_next = $signed(mul_p[ACC_W-1:0]);
            OP_FILT_B: begin
                level_next = lvl_new;
                w_old_next = w_mid_reg;
                w_mid_next = w_new_reg;
                w_new_next = lvl_new;
                since_next = now_reg - last_step_reg;
            end
            OP_DECIDE: begin
                if (idle_w) begin
                    act_next = ACT_IDLE;
                end
                if (peak_w) begin
                    steps_next     = steps_reg + 1'b1;
                    seen_next      = 1'b1;
                    had_step_next  = 1'b1;
                    last_step_next = now_reg;
                    // first step: no interval yet, go straight to walking
                    if (!had_step_reg) begin
                        act_next = ACT_WALK;
                    end
                end
            end
            OP_AVG_A: begin
                inst_next = inst_sat;
                prod_next = $signed(mul_p[ACC_W-1:0]);
            end
            OP_AVG_B: begin
                avg_next = (avg_reg > FREQ_W'(AVG_FLOOR)) ? avg_wtd : inst_reg;
                act_next = (avg_next > cfg.run_thr) ? ACT_RUN : ACT_WALK;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_steps_next  = o_steps_reg;
        o_act_next    = o_act_reg;
        o_seen_next   = o_seen_reg;
        o_settle_next = o_settle_reg;
        if (cmd.load_out) begin
            o_steps_next  = steps_reg;
            o_act_next    = act_reg;
            o_seen_next   = seen_reg;
            o_settle_next = settle_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg    <= 1'b0;
            start_time_reg <= '0;
            level_reg      <= '0;
            w_old_reg      <= '0;
            w_mid_reg      <= '0;
            w_new_reg      <= '0;
            had_step_reg   <= 1'b0;
            last_step_reg  <= '0;
            steps_reg      <= '0;
            act_reg        <= ACT_IDLE;
            avg_reg        <= '0;
        end else begin
            started_reg    <= started_next;
            start_time_reg <= start_time_next;
            level_reg      <= level_next;
            w_old_reg      <= w_old_next;
            w_mid_reg      <= w_mid_next;
            w_new_reg      <= w_new_next;
            had_step_reg   <= had_step_next;
            last_step_reg  <= last_step_next;
            steps_reg      <= steps_next;
            act_reg        <= act_next;
            avg_reg        <= avg_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        z_reg        <= z_next;
        now_reg      <= now_next;
        sum_reg      <= sum_next;
        prod_reg     <= prod_next;
        since_reg    <= since_next;
        inst_reg     <= inst_next;
        seen_reg     <= seen_next;
        settle_reg   <= settle_next;
        o_steps_reg  <= o_steps_next;
        o_act_reg    <= o_act_next;
        o_seen_reg   <= o_seen_next;
        o_settle_reg <= o_settle_next;
    end

    assign out_steps    = o_steps_reg;
    assign out_activity = o_act_reg;
    assign out_seen     = o_seen_reg;
    assign out_settle   = o_settle_reg;

endmodule

// ===== rtl/core/ped_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ped_ctrl: detector sequencer
// Steps one word through the datapath and owns the result valid flag.
// ----------------------------------------------------------------------------
module ped_ctrl
    import ped_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    output dp_cmd_t    cmd,
    input  dp_status_t status
);

    ctrl_state_t state_reg, state_next;
    logic        m_valid_reg, m_valid_next;

    always_comb begin
        state_next    = state_reg;
        s_ready       = 1'b0;
        cmd.op        = OP_NONE;
        cmd.div_start = 1'b0;
        cmd.load_out  = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op     = OP_LATCH;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                cmd.op = OP_CHECK;
                priority if (status.is_clear) begin
                    state_next = ST_OUT;
                end else if (status.settle) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_SQ_X;
                end
            end
            ST_SQ_X: begin
                cmd.op     = OP_SQ_X;
                state_next = ST_SQ_Y;
            end
            ST_SQ_Y: begin
                cmd.op     = OP_SQ_Y;
                state_next = ST_SQ_Z;
            end
            ST_SQ_Z: begin
                cmd.op     = OP_SQ_Z;
                state_next = ST_FILT_A;
            end
            ST_FILT_A: begin
                cmd.op     = OP_FILT_A;
                state_next = ST_FILT_B;
            end
            ST_FILT_B: begin
                cmd.op     = OP_FILT_B;
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                cmd.op = OP_DECIDE;
                // only a repeat step has an interval to turn into a frequency
                if (status.step_hit && status.had_step) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_DIV: begin
                if (status.div_done) begin
                    state_next = ST_AVG_A;
                end
            end
            ST_AVG_A: begin
                cmd.op     = OP_AVG_A;
                state_next = ST_AVG_B;
            end
            ST_AVG_B: begin
                cmd.op     = OP_AVG_B;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// ===== rtl/core/pedometer_step_detector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pedometer_step_detector: accelerometer peak pedometer, top level
// A clear or settling word goes from ST_CHECK straight to ST_OUT; a sample also
// passes the square, filter and decide states; a step that follows an earlier
// step then waits on the radix-2 divider forming 256000/interval and averages.
// One word in flight: the next word is taken the cycle after a result is loaded,
// also while a result still waits in the output register; ST_OUT waits to load
// until the output register is free or being drained.
// Reset (aresetn low, synchronous) clears the detector state and loads the
// register defaults.
// ----------------------------------------------------------------------------
module pedometer_step_detector
    import ped_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    // input words
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [15:0] accel_x, [31:16] accel_y, [47:32] accel_z, [79:48] time_ms
    input  logic [79:0]           s_axis_tdata,
    // [0] command (1 = clear)
    input  logic                  s_axis_tuser,

    // result words
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [15:0] step_count, [17:16] activity, [18] step_seen, [19] settling,
    // [23:20] zero
    output logic [23:0]           m_axis_tdata,

    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t              cfg;
    dp_cmd_t           cmd;
    dp_status_t        status;
    logic [STEP_W-1:0] out_steps;
    logic [ACT_W-1:0]  out_activity;
    logic              out_seen;
    logic              out_settle;

    // register file; write only while no word is in flight
    ped_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencer: accept a word, walk it through the datapath, hand off result
    ped_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .cmd     (cmd),
        .status  (status)
    );

    // filter, peak window, step counter and activity average
    ped_dpath #(
        .TIME_BITS    (TIME_BITS)
    ) u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .cfg          (cfg),
        .in_cmd       (s_axis_tuser),
        .in_x         (s_axis_tdata[15:0]),
        .in_y         (s_axis_tdata[31:16]),
        .in_z         (s_axis_tdata[47:32]),
        .in_time      (s_axis_tdata[79:48]),
        .out_steps    (out_steps),
        .out_activity (out_activity),
        .out_seen     (out_seen),
        .out_settle   (out_settle)
    );

    // pack the result word, lowest field first
    assign m_axis_tdata = {4'b0000, out_settle, out_seen, out_activity, out_steps};

endmodule

// ===== rtl/core/ped_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ped_checker: port-level checks of the pedometer step detector
// Watches the stream ports and the contents of result words.
// ----------------------------------------------------------------------------
module ped_checker
    import ped_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);

    // a stalled result word holds
    a_hold_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result word changed while stalled");

    // one word in flight: taking a word closes the input until it is done
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while a word is in flight");

    // an ignored startup sample never counts a step
    a_settle_no_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tdata[19]) |-> !m_axis_tdata[18])
        else $error("settling word reports a step");

    // a counted step always leaves walking or running
    a_step_active: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tdata[18]) |-> (m_axis_tdata[17:16] != ACT_IDLE))
        else $error("step reported with idle activity");

endmodule

bind pedometer_step_detector ped_checker u_ped_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/tb_pedometer_step_detector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pedometer_step_detector: regression bench for the step detector
// Drives clear and sample words through the input stream and checks every
// result word against a bit-exact tracker of the detector kept in the bench
// or, for typed rows, the directed table, which comes first. Random gait
// sequences follow, under several register settings with random idling
// on both streams and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_pedometer_step_detector;
    import ped_pkg::*;

    localparam int IDLE_PCT         = 23;      // percent chance of idling, each side
    localparam int PHASES           = 9;
    localparam int RANDOM_PER_PHASE = 125;
    localparam int DIR_ROWS         = 22;
    localparam int HOLDOFF_CYCLES   = 600;     // long receiver stall
    localparam int DRAIN_CYCLES     = 40;      // idle wait after the queue empties
    localparam int CYCLE_LIMIT      = 600000;

    // one input word, unpacked from the stream fields
    typedef struct packed {
        logic               clear;
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic [31:0]        stamp;
    } sample_word_t;

    // one result word
    typedef struct packed {
        logic [15:0] count;
        activity_t   act;
        logic        seen;
        logic        settle;
    } step_report_t;

    // directed stimulus; the want_* columns count only where typed is set
    typedef struct {
        logic               clear;
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic [31:0]        stamp;
        bit                 typed;
        logic [15:0]        want_count;
        activity_t          want_act;
        logic               want_seen;
        logic               want_settle;
    } dir_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [79:0]           s_axis_tdata;   // [15:0] x, [31:16] y, [47:32] z, [79:48] time_ms
    logic                  s_axis_tuser;   // [0] command (1 = clear)
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [23:0]           m_axis_tdata;   // [15:0] count, [17:16] activity, [18] seen,
                                           // [19] settling, [23:20] zero
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    pedometer_step_detector u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // ------------------------------------------------------------------------
    // Tracker: the bench's own copy of registers and detector state
    // ------------------------------------------------------------------------
    cfg_t        cfg;
    logic        seen_first;
    logic [31:0] window_open_at;
    longint      level;
    longint      lvl_older, lvl_middle, lvl_newest;
    logic        stepped_once;
    logic [31:0] last_step_at;
    logic [15:0] step_total;
    activity_t   gait_activity;
    logic [15:0] cadence_avg;

    step_report_t expected_reports[$];
    step_report_t want;
    int           mismatch_count = 0;
    int           cycle_count = 0;
    bit           calm = 1'b0;         // no idling on either side
    int           holdoff_left = 0;

    function automatic void clear_tracker();
        seen_first     = 1'b0;
        window_open_at = '0;
        level          = 0;
        lvl_older      = 0;
        lvl_middle     = 0;
        lvl_newest     = 0;
        stepped_once   = 1'b0;
        last_step_at   = '0;
        step_total     = '0;
        gait_activity  = ACT_IDLE;
        cadence_avg    = '0;
    endfunction

    // Advance the tracker by one accepted word and return the result it causes.
    function automatic step_report_t detect_step(input sample_word_t w);
        step_report_t r;
        logic [31:0]  elapsed;
        logic [31:0]  since;
        longint       x, y, z, dev, a, thr, inst;
        r.seen   = 1'b0;
        r.settle = 1'b0;
        if (w.clear) begin
            clear_tracker();
        end else begin
            if (!seen_first) begin
                seen_first     = 1'b1;
                window_open_at = w.stamp;
            end
            elapsed = w.stamp - window_open_at;
            if (elapsed < {16'd0, cfg.startup}) begin
                r.settle = 1'b1;
            end else begin
                x     = w.ax;
                y     = w.ay;
                z     = w.az;
                dev   = ((x * x + y * y + z * z) >>> Q12_SH) - 64'sd4096;
                a     = (cfg.alpha > 9'd256) ? 64'sd256 : longint'(cfg.alpha);
                thr   = longint'(cfg.threshold);
                since = w.stamp - last_step_at;
                // floor division by 256: arithmetic shift of a signed value
                level      = (a * dev + (64'sd256 - a) * level) >>> 8;
                lvl_older  = lvl_middle;
                lvl_middle = lvl_newest;
                lvl_newest = level;
                if (stepped_once && since > {16'd0, cfg.idle})
                    gait_activity = ACT_IDLE;
                if (lvl_middle > lvl_older && lvl_middle > lvl_newest && lvl_middle > thr &&
                    (!stepped_once || since > {16'd0, cfg.min_gap})) begin
                    step_total = step_total + 16'd1;
                    r.seen     = 1'b1;
                    if (stepped_once) begin
                        if (since == 32'd0)
                            inst = 65535;
                        else
                            inst = 64'sd256000 / longint'(since);
                        if (inst > 65535)
                            inst = 65535;
                        if (cadence_avg > 16'd25)
                            cadence_avg = 16'((a * inst +
                                (64'sd256 - a) * longint'(cadence_avg)) >>> 8);
                        else
                            cadence_avg = 16'(inst);
                        gait_activity = (cadence_avg > cfg.run_thr) ? ACT_RUN : ACT_WALK;
                    end else begin
                        gait_activity = ACT_WALK;
                    end
                    stepped_once = 1'b1;
                    last_step_at = w.stamp;
                end
            end
        end
        r.count = step_total;
        r.act   = gait_activity;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Clock, cycle limit
    // ------------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("pedometer_step_detector regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random ready, a long hold-off on request, none while calm
    // ------------------------------------------------------------------------
    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (holdoff_left > 0) begin
                // hold ready low; the sender keeps offering so the block backs up
                holdoff_left = holdoff_left - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: compare each accepted word with the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (expected_reports.size() == 0) begin
                $error("result word %h arrived with nothing expected", m_axis_tdata);
                mismatch_count = mismatch_count + 1;
            end else begin
                want = expected_reports.pop_front();
                if (m_axis_tdata[15:0] !== want.count) begin
                    $error("step_count: expected %0d, got %0d", want.count, m_axis_tdata[15:0]);
                    mismatch_count = mismatch_count + 1;
                end
                if (m_axis_tdata[17:16] !== want.act) begin
                    $error("activity: expected %0d, got %0d", want.act, m_axis_tdata[17:16]);
                    mismatch_count = mismatch_count + 1;
                end
                if (m_axis_tdata[18] !== want.seen) begin
                    $error("step_seen: expected %0d, got %0d", want.seen, m_axis_tdata[18]);
                    mismatch_count = mismatch_count + 1;
                end
                if (m_axis_tdata[19] !== want.settle) begin
                    $error("settling: expected %0d, got %0d", want.settle, m_axis_tdata[19]);
                    mismatch_count = mismatch_count + 1;
                end
                if (m_axis_tdata[23:20] !== 4'd0) begin
                    $error("pad: expected 0, got %0d", m_axis_tdata[23:20]);
                    mismatch_count = mismatch_count + 1;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender and register port
    // ------------------------------------------------------------------------

    // Offer one word, with random idle cycles first; return at its accepting edge.
    task automatic send_word(input sample_word_t w);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= w.clear;
        s_axis_tdata  <= {w.stamp, w.az, w.ay, w.ax};
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    // Write one register (setup then access cycle), read it back, and mirror it.
    // Upper pwdata bits carry junk; the register keeps only its own width.
    task automatic program_reg(input reg_idx_t idx, input logic [31:0] value);
        logic [31:0] kept;
        case (idx)
            REG_ALPHA: kept = value & 32'h0000_01FF;
            REG_THR:   kept = value & 32'h000F_FFFF;
            default:   kept = value & 32'h0000_FFFF;
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        // written at this edge; now read it back
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== kept) begin
            $error("register %0d readback: expected %h, got %h", idx, kept, prdata);
            mismatch_count = mismatch_count + 1;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_ALPHA:   cfg.alpha     = kept[ALPHA_W-1:0];
            REG_THR:     cfg.threshold = kept[THR_W-1:0];
            REG_GAP:     cfg.min_gap   = kept[MS_W-1:0];
            REG_IDLE:    cfg.idle      = kept[MS_W-1:0];
            REG_STARTUP: cfg.startup   = kept[MS_W-1:0];
            default:     cfg.run_thr   = kept[MS_W-1:0];
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    dir_row_t directed_rows [DIR_ROWS];

    initial begin
        sample_word_t w;
        step_report_t rpt;
        cfg_t         plan;
        int           p, n, i, pick, lift, zv, xv, yv;
        int unsigned  period, stride, amp;
        logic [31:0]  stamp_now, gait_t0, phase_ms;

        // drive every input to a known value from time zero
        aresetn       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;

        cfg.alpha     = ALPHA_W'(ALPHA_RST);
        cfg.threshold = THR_W'(THR_RST);
        cfg.min_gap   = MS_W'(GAP_RST);
        cfg.idle      = MS_W'(IDLE_RST);
        cfg.startup   = MS_W'(STARTUP_RST);
        cfg.run_thr   = MS_W'(RUN_RST);
        clear_tracker();

        // clr  x         y         z         time           typed cnt   act       seen  settle
        directed_rows = '{
            // clear straight out of reset
            '{1'b1, 16'sh0000, 16'sh0000, 16'sh0000, 32'd0,  1'b1, 16'd0, ACT_IDLE, 1'b0, 1'b0},
            // first sample opens the startup window
            '{1'b0, 16'sh1000, 16'sh0000, 16'sh0000, 32'd1000, 1'b1, 16'd0, ACT_IDLE, 1'b0, 1'b1},
            // last millisecond of the window, negative extremes
            '{1'b0, 16'sh8000, 16'sh8000, 16'sh8000, 32'd1499, 1'b1, 16'd0, ACT_IDLE, 1'b0, 1'b1},
            // window over: largest magnitude, then zero vector -> first step, no gap check
            '{1'b0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 32'd1500, 1'b0, 16'd0, ACT_IDLE, 1'b0, 1'b0},
            '{1'b0, 16'sh0000, 16'sh0000, 16'sh0000, 32'd1520, 1'b0, 16'd0, ACT_IDLE, 1'b0, 1'b0},
            // a peak inside the minimum gap must not count
            '{1'b0, 16'sh4000, 16'sh0000, 16'sh0000, 32'd1540, 1'b0, 16'd0, ACT_IDLE, 1'b0, 1'b0},
            '{1'b0, 16'sh4000, 16'sh0000, 16'sh0000, 32'd1560, 1'b0, 16'd0, ACT_IDLE, 1'b0, 1'b0},
            '{1'b0, 16'sh0000, 16'sh1000, 16'sh0000, 32'd1580, 1'b0, 16'd0, ACT_IDLE, 1'b0, 1'b0},
            // second step after the gap: first frequency sample
            '{1'b0, 16'sh0000, 16'sh0000, 16'sh1000, 32'd1900, 1'b0, 16'd0, ACT_IDLE, 1'b0, 1'b0},
            '{1'b0, 16'sh4000, 16'sh0000, 16'sh0000, 32'd1950, 1'b0, 16'd0, ACT_IDLE, 1'b0, 1'b0},
            '{1'b0, 16'sh4E20, 16'sh0000, 16'sh0000, 32'd1970, 1'b0, 16'd0, ACT_IDLE, 1'b0, 1'b0},
            '{1'b0, 16'sh0000, 16'sh0000, 16'sh1000, 32'd1990, 1'b0, 16'd0, ACT_IDLE, 1'b0, 1'b0},
            // third step, short interval: frequency average moves
            '{1'b0, 16'sh0000, 16'shC000, 16'sh0000, 32'd2250, 1'b0, 16'd0, ACT_IDLE, 1'b0, 1'b0},
            '{1'b0, 16'sh0000, 16'shB1E0, 16'sh0000, 32'd2270, 1'b0, 16'd0, ACT_IDLE, 1'b0, 1'b0},
            '{1'b0, 16'sh0000, 16'sh0000, 16'shF000, 32'd2290, 1'b0, 16'd0, ACT_IDLE, 1'b0, 1'b0},
            // long silence: idle timeout drops activity
            '{1'b0, 16'sh0000, 16'sh0000, 16'sh1000, 32'd6000, 1'b0, 16'd0, ACT_IDLE, 1'b0, 1'b0},
            '{1'b0, 16'sh8000, 16'sh0000, 16'sh0000, 32'd6020, 1'b0, 16'd0, ACT_IDLE, 1'b0, 1'b0},
            // clear with every data bit set
            '{1'b1, 16'shFFFF, 16'shFFFF, 16'shFFFF, 32'hFFFF_FFFF, 1'b1, 16'd0, ACT_IDLE,
              1'b0, 1'b0},
            // startup window across the timestamp wrap
            '{1'b0, 16'sh0000, 16'sh0000, 16'sh1000, 32'hFFFF_FF00, 1'b1, 16'd0, ACT_IDLE,
              1'b0, 1'b1},
            '{1'b0, 16'sh0000, 16'sh0000, 16'sh1000, 32'h0000_0100, 1'b0, 16'd0, ACT_IDLE,
              1'b0, 1'b0},
            // timestamp steps back into the window: ignored again
            '{1'b0, 16'sh0000, 16'sh0000, 16'sh1000, 32'hFFFF_FF80, 1'b0, 16'd0, ACT_IDLE,
              1'b0, 1'b0},
            '{1'b1, 16'sh0000, 16'sh0000, 16'sh0000, 32'd0,  1'b1, 16'd0, ACT_IDLE, 1'b0, 1'b0}
        };

        // hold reset, once
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table, register defaults
        for (i = 0; i < DIR_ROWS; i++) begin
            w.clear = directed_rows[i].clear;
            w.ax    = directed_rows[i].ax;
            w.ay    = directed_rows[i].ay;
            w.az    = directed_rows[i].az;
            w.stamp = directed_rows[i].stamp;
            send_word(w);
            rpt = detect_step(w);
            if (directed_rows[i].typed) begin
                rpt.count  = directed_rows[i].want_count;
                rpt.act    = directed_rows[i].want_act;
                rpt.seen   = directed_rows[i].want_seen;
                rpt.settle = directed_rows[i].want_settle;
            end
            expected_reports.push_back(rpt);
        end

        stamp_now = 32'd10000;
        for (p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                // drain, let the block go quiet, then reprogram every register
                s_axis_tvalid <= 1'b0;
                while (expected_reports.size() != 0) @(posedge aclk);
                repeat (DRAIN_CYCLES) @(posedge aclk);
                case (p)
                    1: plan = '{alpha: 9'd256, threshold: 20'd1000, min_gap: 16'd200,
                                idle: 16'd1500, startup: 16'd100, run_thr: 16'd400};
                    2: plan = '{alpha: 9'd0, threshold: 20'd0, min_gap: 16'd0,
                                idle: 16'd0, startup: 16'd0, run_thr: 16'd0};
                    3: plan = '{alpha: 9'h1FF, threshold: 20'hFFFFF, min_gap: 16'hFFFF,
                                idle: 16'hFFFF, startup: 16'hFFFF, run_thr: 16'hFFFF};
                    4: plan = '{alpha: 9'd128, threshold: 20'd800, min_gap: 16'd250,
                                idle: 16'd3000, startup: 16'd300, run_thr: 16'd563};
                    8: plan = '{alpha: ALPHA_W'(ALPHA_RST), threshold: THR_W'(THR_RST),
                                min_gap: MS_W'(GAP_RST), idle: MS_W'(IDLE_RST),
                                startup: MS_W'(STARTUP_RST), run_thr: MS_W'(RUN_RST)};
                    default: begin
                        plan.alpha     = 9'($urandom_range(1, 300));
                        plan.threshold = 20'($urandom_range(0, 30000));
                        plan.min_gap   = 16'($urandom_range(0, 600));
                        plan.idle      = 16'($urandom_range(0, 4000));
                        plan.startup   = 16'($urandom_range(0, 800));
                        plan.run_thr   = 16'($urandom_range(0, 1500));
                    end
                endcase
                program_reg(REG_ALPHA,   {23'($urandom), plan.alpha});
                program_reg(REG_THR,     {12'($urandom), plan.threshold});
                program_reg(REG_GAP,     {16'($urandom), plan.min_gap});
                program_reg(REG_IDLE,    {16'($urandom), plan.idle});
                program_reg(REG_STARTUP, {16'($urandom), plan.startup});
                program_reg(REG_RUN,     {16'($urandom), plan.run_thr});
                @(posedge aclk);
            end

            calm = (p == 1);
            if (p == 4)
                holdoff_left = HOLDOFF_CYCLES;

            // new gait for the phase
            gait_t0 = stamp_now;
            period  = $urandom_range(250, 1000);
            stride  = $urandom_range(10, 40);
            amp     = $urandom_range(2000, 16000);

            for (n = 0; n < RANDOM_PER_PHASE; n++) begin
                pick    = $urandom_range(0, 99);
                w.clear = 1'b0;
                if (pick < 2) begin
                    // clear with random payload
                    w.clear = 1'b1;
                    w.ax    = 16'($urandom);
                    w.ay    = 16'($urandom);
                    w.az    = 16'($urandom);
                    w.stamp = $urandom;
                end else if (pick < 9) begin
                    // noise: any vector, timestamp anywhere or near the walk
                    w.ax    = 16'($urandom);
                    w.ay    = 16'($urandom);
                    w.az    = 16'($urandom);
                    w.stamp = (pick < 5) ? $urandom : stamp_now + $urandom_range(0, 50);
                end else begin
                    if (pick < 12) begin
                        // pause that may be long enough to fall idle, then a new cadence
                        stamp_now = stamp_now + $urandom_range(1500, 70000);
                        gait_t0   = stamp_now;
                        period    = $urandom_range(250, 1000);
                        stride    = $urandom_range(10, 40);
                        amp       = $urandom_range(2000, 16000);
                    end else if (pick == 12) begin
                        // jump close to the timestamp wrap
                        stamp_now = 32'hFFFF_FFFF - $urandom_range(0, 3000);
                        gait_t0   = stamp_now;
                    end
                    stamp_now = stamp_now + stride;
                    phase_ms  = (stamp_now - gait_t0) % period;
                    // heel strike lifts the vertical axis for a third of the period
                    lift  = (phase_ms < period / 3) ? int'(amp) : 0;
                    zv    = 4096 + lift + int'($urandom_range(0, 600)) - 300;
                    xv    = int'($urandom_range(0, 1200)) - 600;
                    yv    = int'($urandom_range(0, 1200)) - 600;
                    w.ax    = 16'(xv);
                    w.ay    = 16'(yv);
                    w.az    = 16'(zv);
                    w.stamp = stamp_now;
                end
                send_word(w);
                expected_reports.push_back(detect_step(w));
            end
        end

        // all stimulus accepted; wait out the tail
        s_axis_tvalid <= 1'b0;
        calm = 1'b0;
        while (expected_reports.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("pedometer_step_detector regression: pass");
        end else begin
            $display("pedometer_step_detector regression: fail");
        end
        $finish;
    end

endmodule

// ===== pedometer_step_detector.f =====
rtl/core/ped_pkg.sv
rtl/core/ped_cfg.sv
rtl/core/ped_div.sv
rtl/core/ped_dpath.sv
rtl/core/ped_ctrl.sv
rtl/core/pedometer_step_detector.sv
rtl/core/ped_checker.sv
tb/tb_pedometer_step_detector.sv
